### design/sda_pkg.sv
package sda_pkg;

  // arccos table geometry
  localparam int ACOS_TABLE_DEPTH = 256;
  localparam int IdxW = $clog2(ACOS_TABLE_DEPTH + 1);

  // angle constants, Q3.12
  localparam logic signed [15:0] PI_Q12     = 16'sd12868;
  localparam logic signed [15:0] TWO_PI_Q12 = 16'sd25736;
  localparam logic signed [15:0] NEG_PI_Q12 = -16'sd12868;

  // pi and half pi in Q30 for the table build
  localparam logic [63:0] PI_Q30      = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic [14:0] FLAT_RESET = 15'd14746;

  typedef logic signed [31:0] coord_t;
  typedef logic signed [15:0] normal_t;
  typedef logic signed [32:0] diff_t;
  typedef logic signed [33:0] dot_t;
  typedef logic signed [50:0] side_t;
  typedef logic [13:0]        acos_entry_t;
  typedef acos_entry_t        acos_tab_t [ACOS_TABLE_DEPTH + 1];

  typedef enum logic [1:0] {
    FOLD_CONCAVE = 2'd0,
    FOLD_CONVEX  = 2'd1,
    FOLD_FLAT    = 2'd2,
    FOLD_INCOMPAT = 2'd3
  } fold_kind_e;

  // payload handed from cell to cell; component 0 is consumed by each cell
  typedef struct packed {
    coord_t  [2:0] ac;
    normal_t [2:0] an;
    coord_t  [2:0] bc;
    normal_t [2:0] bn;
    dot_t          d;
    side_t         s1;
    side_t         s2;
  } cell_t;

  // lookup stage result
  typedef struct packed {
    acos_entry_t        t0;
    logic signed [15:0] delta;
    logic [14:0]        frac;
    fold_kind_e         kind;
  } lk_t;

  // cosine of th (Q30, 0..pi) in Q30, truncated taylor series
  function automatic longint cos_q30(logic [63:0] th);
    logic [63:0] r;
    logic [63:0] t2;
    logic [63:0] term;
    logic        neg;
    longint      sum;
    r   = th;
    neg = 1'b0;
    if (r > HALF_PI_Q30) begin
      r   = (r > PI_Q30) ? 64'd0 : PI_Q30 - r;
      neg = 1'b1;
    end
    t2   = (r * r) >> 30;
    term = 64'd1 << 30;
    sum  = longint'(term);
    term = ((term * t2) >> 30) / 64'd2;   sum -= longint'(term);
    term = ((term * t2) >> 30) / 64'd12;  sum += longint'(term);
    term = ((term * t2) >> 30) / 64'd30;  sum -= longint'(term);
    term = ((term * t2) >> 30) / 64'd56;  sum += longint'(term);
    term = ((term * t2) >> 30) / 64'd90;  sum -= longint'(term);
    term = ((term * t2) >> 30) / 64'd132; sum += longint'(term);
    term = ((term * t2) >> 30) / 64'd182; sum -= longint'(term);
    term = ((term * t2) >> 30) / 64'd240; sum += longint'(term);
    term = ((term * t2) >> 30) / 64'd306; sum -= longint'(term);
    term = ((term * t2) >> 30) / 64'd380; sum += longint'(term);
    term = ((term * t2) >> 30) / 64'd462; sum -= longint'(term);
    term = ((term * t2) >> 30) / 64'd552; sum += longint'(term);
    return neg ? -sum : sum;
  endfunction

  // arccos at evenly spaced points of [-1, 1], found by bisection
  function automatic acos_tab_t build_acos_tab();
    acos_tab_t   tab;
    longint      target;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] th;
    for (int i = 0; i <= ACOS_TABLE_DEPTH; i++) begin
      target = longint'(2 * i - ACOS_TABLE_DEPTH) * (longint'(1) << 30);
      lo = 64'd0;
      hi = PI_Q30;
      for (int n = 0; n < 32; n++) begin
        mid = (lo + hi) >> 1;
        if (longint'(ACOS_TABLE_DEPTH) * cos_q30(mid) > target) begin
          lo = mid;
        end else begin
          hi = mid;
        end
      end
      th = (lo + hi) >> 1;
      tab[i] = acos_entry_t'((th + (64'd1 << 17)) >> 18);
    end
    tab[0] = acos_entry_t'(PI_Q12);
    tab[ACOS_TABLE_DEPTH] = '0;
    return tab;
  endfunction

  localparam acos_tab_t ACOS_TAB = build_acos_tab();

endpackage

### design/sda_in_if.sv
interface sda_in_if import sda_pkg::*; ();
  logic    valid;
  logic    ready;
  coord_t  a_center_x;
  coord_t  a_center_y;
  coord_t  a_center_z;
  normal_t a_normal_x;
  normal_t a_normal_y;
  normal_t a_normal_z;
  coord_t  b_center_x;
  coord_t  b_center_y;
  coord_t  b_center_z;
  normal_t b_normal_x;
  normal_t b_normal_y;
  normal_t b_normal_z;

  modport source (
    output valid, a_center_x, a_center_y, a_center_z, a_normal_x, a_normal_y, a_normal_z,
    output b_center_x, b_center_y, b_center_z, b_normal_x, b_normal_y, b_normal_z,
    input  ready
  );

  modport sink (
    input  valid, a_center_x, a_center_y, a_center_z, a_normal_x, a_normal_y, a_normal_z,
    input  b_center_x, b_center_y, b_center_z, b_normal_x, b_normal_y, b_normal_z,
    output ready
  );
endinterface

### design/sda_out_if.sv
interface sda_out_if ();
  logic              valid;
  logic              ready;
  logic signed [15:0] dihedral_angle;
  logic [1:0]         fold_kind;

  modport source (
    output valid, dihedral_angle, fold_kind,
    input  ready
  );

  modport sink (
    input  valid, dihedral_angle, fold_kind,
    output ready
  );
endinterface

### design/sda_dot_cell.sv
module sda_dot_cell import sda_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  cell_t data_i,
  output logic  valid_o,
  input  logic  ready_i,
  output cell_t data_o
);

  logic               valid_q;
  cell_t              data_q;
  cell_t              data_d;
  diff_t              diff;
  logic signed [31:0] prod_n;
  logic signed [48:0] prod_b;
  logic signed [48:0] prod_a;

  assign ready_o = !valid_q || ready_i;

  // one component of the three dot products
  always_comb begin
    diff   = diff_t'(signed'(data_i.ac[0])) - diff_t'(signed'(data_i.bc[0]));
    prod_n = signed'(data_i.an[0]) * signed'(data_i.bn[0]);
    prod_b = diff * signed'(data_i.bn[0]);
    prod_a = diff * signed'(data_i.an[0]);

    data_d    = data_i;
    data_d.d  = data_i.d + dot_t'(prod_n);
    data_d.s1 = data_i.s1 + side_t'(prod_b);
    data_d.s2 = data_i.s2 - side_t'(prod_a);
    // move the next component into place for the neighbor
    data_d.ac = {coord_t'(0), data_i.ac[2:1]};
    data_d.an = {normal_t'(0), data_i.an[2:1]};
    data_d.bc = {coord_t'(0), data_i.bc[2:1]};
    data_d.bn = {normal_t'(0), data_i.bn[2:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### design/sda_acos_lookup.sv
module sda_acos_lookup import sda_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  dot_t        d_i,
  input  side_t       s1_i,
  input  side_t       s2_i,
  input  logic [14:0] flat_threshold_i,
  output logic        valid_o,
  input  logic        ready_i,
  output lk_t         data_o
);

  localparam logic [31:0] PosMul = 32'(ACOS_TABLE_DEPTH);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(ACOS_TABLE_DEPTH);

  logic               valid_q;
  lk_t                data_q;
  lk_t                data_d;
  logic signed [34:0] rnd;
  logic signed [34:0] c_full;
  logic signed [15:0] c_clamp;
  logic [15:0]        u;
  logic [31:0]        pos;
  logic [IdxW-1:0]    idx;
  logic [IdxW-1:0]    idx_nx;
  acos_entry_t        t1;
  dot_t               thr_ext;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    // round dot to Q1.14 and clamp to [-1, 1]
    rnd    = 35'(d_i) + 35'sd8192;
    c_full = rnd >>> 14;
    if (c_full > 35'sd16384) begin
      c_clamp = 16'sd16384;
    end else if (c_full < -35'sd16384) begin
      c_clamp = -16'sd16384;
    end else begin
      c_clamp = c_full[15:0];
    end
    u      = 16'(c_clamp + 16'sd16384);
    pos    = {16'd0, u} * PosMul;
    idx    = pos[15 +: IdxW];
    idx_nx = (idx == IdxLast) ? idx : idx + 1'b1;
    t1     = ACOS_TAB[idx_nx];

    data_d.t0    = ACOS_TAB[idx];
    data_d.delta = $signed({2'b00, t1}) - $signed({2'b00, data_d.t0});
    data_d.frac  = pos[14:0];

    thr_ext = $signed({5'd0, flat_threshold_i, 14'd0});
    if (!s1_i[50] && !s2_i[50]) begin
      data_d.kind = FOLD_CONCAVE;
    end else if (s1_i[50] && s2_i[50]) begin
      data_d.kind = FOLD_CONVEX;
    end else if (d_i > thr_ext) begin
      data_d.kind = FOLD_FLAT;
    end else begin
      data_d.kind = FOLD_INCOMPAT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### design/signed_dihedral_angle.sv
// signed dihedral angle between two mesh faces
//
// in_i carries one item per edge pair: two face centers (Q15.16) and two
// unit normals (Q1.14). out_o returns one item per input item, in order:
// the dihedral angle in Q3.12 and the fold kind (concave, convex, flat,
// incompatible). flat_threshold_i is written when flat_threshold_we_i is
// high at a clock edge; reset loads 14746 (about 0.9 in Q1.14).
//
// a row of three dot-product cells adds one vector component each, then a
// lookup stage rounds and clamps the normal dot and reads the arccos table,
// and the output stage interpolates and applies the fold rule.
// an accepted item passes the three cell registers, the lookup register and
// the output register in that order before out_o.valid shows it.
// throughput: one item per cycle while out_o.ready stays high; every stage holds one item.
// each stage has its own valid bit, so bubbles close up; when the receiver
// stalls, items pile up behind the output register and in_i.ready drops
// only once all five stages are full.
// reset clears all valid bits; no item is in flight afterwards.
module signed_dihedral_angle import sda_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  sda_in_if.sink      in_i,
  sda_out_if.source   out_o,
  input  logic        flat_threshold_we_i,
  input  logic [14:0] flat_threshold_i
);

  localparam int NumCells = 3;

  // threshold register
  logic [14:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= FLAT_RESET;
    end else if (flat_threshold_we_i) begin
      thr_q <= flat_threshold_i;
    end
  end

  // chain of dot-product cells, slot 0 is the input item
  cell_t cell_pl  [NumCells + 1];
  logic  cell_vld [NumCells + 1];
  logic  cell_rdy [NumCells + 1];

  always_comb begin
    cell_pl[0].ac = {in_i.a_center_z, in_i.a_center_y, in_i.a_center_x};
    cell_pl[0].an = {in_i.a_normal_z, in_i.a_normal_y, in_i.a_normal_x};
    cell_pl[0].bc = {in_i.b_center_z, in_i.b_center_y, in_i.b_center_x};
    cell_pl[0].bn = {in_i.b_normal_z, in_i.b_normal_y, in_i.b_normal_x};
    cell_pl[0].d  = '0;
    cell_pl[0].s1 = '0;
    cell_pl[0].s2 = '0;
  end

  assign cell_vld[0] = in_i.valid;
  assign in_i.ready  = cell_rdy[0];

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    sda_dot_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cell_vld[g]),
      .ready_o (cell_rdy[g]),
      .data_i  (cell_pl[g]),
      .valid_o (cell_vld[g + 1]),
      .ready_i (cell_rdy[g + 1]),
      .data_o  (cell_pl[g + 1])
    );
  end

  // arccos lookup and fold classification
  logic lk_vld;
  lk_t  lk_pl;
  logic out_rdy;

  sda_acos_lookup u_lookup (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (cell_vld[NumCells]),
    .ready_o          (cell_rdy[NumCells]),
    .d_i              (cell_pl[NumCells].d),
    .s1_i             (cell_pl[NumCells].s1),
    .s2_i             (cell_pl[NumCells].s2),
    .flat_threshold_i (thr_q),
    .valid_o          (lk_vld),
    .ready_i          (out_rdy),
    .data_o           (lk_pl)
  );

  // output stage: interpolate, then pi minus arccos and the fold rule
  logic               out_vld_q;
  logic signed [15:0] angle_q;
  fold_kind_e         kind_q;
  logic signed [15:0] angle_d;
  logic signed [31:0] prod;
  logic signed [31:0] step_full;
  logic signed [16:0] acos_v;
  logic signed [16:0] base;

  assign out_rdy = !out_vld_q || out_o.ready;

  always_comb begin
    prod      = lk_pl.delta * $signed({1'b0, lk_pl.frac});
    // round the weighted step, floor after adding half
    step_full = (prod + 32'sd16384) >>> 15;
    acos_v    = $signed({3'b000, lk_pl.t0}) + step_full[16:0];
    base      = 17'(PI_Q12) - acos_v;
    case (lk_pl.kind)
      FOLD_CONCAVE:  angle_d = base[15:0];
      FOLD_FLAT:     angle_d = base[15:0];
      FOLD_CONVEX:   angle_d = TWO_PI_Q12 - base[15:0];
      FOLD_INCOMPAT: angle_d = NEG_PI_Q12;
      default:       angle_d = NEG_PI_Q12;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_rdy) begin
      out_vld_q <= lk_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && lk_vld) begin
      angle_q <= angle_d;
      kind_q  <= lk_pl.kind;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.dihedral_angle = angle_q;
  assign out_o.fold_kind      = kind_q;

  // incompatible orientation always reports minus pi
  a_incompat_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && kind_q == FOLD_INCOMPAT) |-> (angle_q == NEG_PI_Q12))
    else $error("incompatible item without minus pi");

  // concave and flat angles stay within [0, pi]
  a_open_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (kind_q == FOLD_CONCAVE || kind_q == FOLD_FLAT))
      |-> (angle_q >= 16'sd0 && angle_q <= PI_Q12))
    else $error("concave or flat angle out of range");

  // convex angles stay within [pi, two pi]
  a_convex_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && kind_q == FOLD_CONVEX)
      |-> (angle_q >= PI_Q12 && angle_q <= TWO_PI_Q12))
    else $error("convex angle out of range");

  // an item the output stage takes from the lookup stage is in the output register next
  a_lookup_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lk_vld && out_rdy) |=> out_vld_q)
    else $error("lookup item lost");

endmodule
